[rtl/raw_block_coefficient_decoder_macros.svh]
// Assertion macros used by the coefficient decoder dequantiser.
// Expects clk and rst_n in scope where used.
`ifndef RAW_BLOCK_COEFFICIENT_DECODER_MACROS_SVH
`define RAW_BLOCK_COEFFICIENT_DECODER_MACROS_SVH

// same-cycle implication
`define RBCD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbcd assertion failed");

// next-cycle implication
`define RBCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbcd assertion failed");

`endif

[rtl/rbcd_pkg.sv]
// Package for the coefficient decoder: codes, scan and prefix-code tables,
// the issue struct between the parser and the dequantiser. No dependencies.
`default_nettype none
package rbcd_pkg;

  localparam int MAX_AC_CODE_BITS = 18;
  localparam int MAX_DC_CODE_BITS = 13;
  localparam int AC_COUNT         = 194;
  localparam int QADDR_W          = 7;
  localparam int QDATA_W          = 31;

  typedef enum logic [1:0] {
    CMD_QWRITE = 2'd0,
    CMD_TILE   = 2'd1,
    CMD_BLOCK  = 2'd2,
    CMD_BIT    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RK_COEF = 2'd0,
    RK_EOB  = 2'd1,
    RK_ERR  = 2'd2
  } rkind_t;

  typedef struct packed {
    logic               vld;
    rkind_t             kind;
    logic [5:0]         pos;
    logic               is_dc;
    logic               half;
    logic signed [31:0] value;
  } issue_t;

  localparam logic [5:0] ZZ_ORDER [64] = '{
    6'd0, 6'd1, 6'd8, 6'd16, 6'd9, 6'd2, 6'd3, 6'd10, 6'd17, 6'd24, 6'd32, 6'd25,
    6'd18, 6'd11, 6'd4, 6'd5, 6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41,
    6'd34, 6'd27, 6'd20, 6'd13, 6'd6, 6'd7, 6'd14, 6'd21, 6'd28, 6'd35, 6'd42,
    6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36, 6'd29, 6'd22, 6'd15, 6'd23, 6'd30,
    6'd37, 6'd44, 6'd51, 6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63};

  localparam logic [5:0] HALF_ORDER [32] = '{
    6'd0, 6'd1, 6'd2, 6'd3, 6'd8, 6'd9, 6'd16, 6'd17, 6'd10, 6'd11, 6'd4, 6'd5,
    6'd6, 6'd7, 6'd12, 6'd13, 6'd18, 6'd19, 6'd24, 6'd25, 6'd26, 6'd27, 6'd20,
    6'd21, 6'd14, 6'd15, 6'd22, 6'd23, 6'd28, 6'd29, 6'd30, 6'd31};

  localparam logic [4:0] DC_LEN_TAB [16] = '{
    5'd2, 5'd3, 5'd3, 5'd3, 5'd3, 5'd3, 5'd5, 5'd5, 5'd6, 5'd12, 5'd12, 5'd12,
    5'd12, 5'd5, 5'd12, 5'd13};

  localparam logic [17:0] DC_CODE_TAB [16] = '{
    18'h0, 18'h2, 18'h3, 18'h4, 18'h5, 18'h6, 18'h1C, 18'h1D, 18'h3E, 18'hFF4,
    18'hFF5, 18'hFF7, 18'hFED, 18'h1E, 18'hFFE, 18'h1FFE};

  localparam logic [4:0] AC_SHORT_LEN [40] = '{
    5'd2, 5'd2, 5'd3, 5'd4, 5'd4, 5'd4, 5'd5, 5'd5, 5'd5, 5'd6, 5'd6, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd8, 5'd8, 5'd8, 5'd9, 5'd9, 5'd9, 5'd9, 5'd9, 5'd10, 5'd10,
    5'd10, 5'd10, 5'd10, 5'd11, 5'd11, 5'd12, 5'd12, 5'd12, 5'd12, 5'd12, 5'd12,
    5'd13, 5'd13, 5'd13, 5'd13};

  localparam logic [17:0] AC_CODE_TAB [AC_COUNT] = '{
    18'h00000, 18'h00001, 18'h00004, 18'h0000B, 18'h0000C, 18'h0000A,
    18'h0001A, 18'h0001B, 18'h0001C, 18'h0003A, 18'h0003B, 18'h00078,
    18'h00079, 18'h0007A, 18'h0007B, 18'h000F8, 18'h000F9, 18'h000FA,
    18'h001F6, 18'h001F7, 18'h001F8, 18'h001F9, 18'h001FA, 18'h003F6,
    18'h003F7, 18'h003F8, 18'h003F9, 18'h003FA, 18'h007F8, 18'h007F9,
    18'h00FED, 18'h00FF4, 18'h00FF5, 18'h00FF7, 18'h00FEC, 18'h00FF6,
    18'h01FDC, 18'h01FDD, 18'h01FDE, 18'h01FDF, 18'h07FC0, 18'h0FF84,
    18'h0FF85, 18'h0FF86, 18'h0FF87, 18'h0FF88, 18'h0FF89, 18'h0FF8A,
    18'h0FF8B, 18'h0FF8C, 18'h0FF8D, 18'h0FF8E, 18'h0FF8F, 18'h0FF90,
    18'h0FF91, 18'h0FF92, 18'h0FF93, 18'h0FF94, 18'h0FF95, 18'h0FF96,
    18'h0FF97, 18'h0FF98, 18'h0FF99, 18'h0FF9A, 18'h0FF9B, 18'h0FF9C,
    18'h0FF9D, 18'h0FF9E, 18'h0FF9F, 18'h0FFA0, 18'h0FFA1, 18'h0FFA2,
    18'h0FFA3, 18'h0FFA4, 18'h0FFA5, 18'h0FFA6, 18'h0FFA7, 18'h0FFA8,
    18'h0FFA9, 18'h0FFAA, 18'h0FFAB, 18'h0FFAC, 18'h0FFAE, 18'h0FFAF,
    18'h0FFB0, 18'h0FFB1, 18'h0FFB2, 18'h0FFB3, 18'h0FFB4, 18'h0FFB6,
    18'h0FFB7, 18'h0FFB8, 18'h0FFB9, 18'h0FFBA, 18'h0FFBB, 18'h0FFBC,
    18'h0FFBE, 18'h0FFBF, 18'h0FFC0, 18'h0FFC1, 18'h0FFC2, 18'h0FFC3,
    18'h0FFC4, 18'h0FFC5, 18'h0FFC7, 18'h0FFC8, 18'h0FFC9, 18'h0FFCA,
    18'h0FFCB, 18'h0FFCC, 18'h0FFCD, 18'h0FFCE, 18'h0FFD0, 18'h0FFD1,
    18'h0FFD2, 18'h0FFD3, 18'h0FFD4, 18'h0FFD5, 18'h0FFD6, 18'h0FFD7,
    18'h0FFD9, 18'h0FFDA, 18'h0FFDB, 18'h0FFDC, 18'h0FFDD, 18'h0FFDE,
    18'h0FFDF, 18'h0FFE0, 18'h0FFE2, 18'h0FFE3, 18'h0FFE4, 18'h0FFE5,
    18'h0FFE6, 18'h0FFE7, 18'h0FFE8, 18'h0FFE9, 18'h0FFEB, 18'h0FFEC,
    18'h0FFED, 18'h0FFEE, 18'h0FFEF, 18'h0FFF0, 18'h0FFF1, 18'h0FFF2,
    18'h0FFF3, 18'h0FFF5, 18'h0FFF6, 18'h0FFF7, 18'h0FFF8, 18'h0FFF9,
    18'h0FFFA, 18'h0FFFB, 18'h0FFFC, 18'h0FFFD, 18'h3FEB5, 18'h3FEB6,
    18'h3FEB7, 18'h3FED5, 18'h3FED6, 18'h3FED7, 18'h3FEF5, 18'h3FEF6,
    18'h3FEF7, 18'h3FF19, 18'h3FEB4, 18'h3FF1A, 18'h3FF1B, 18'h3FED4,
    18'h3FF3D, 18'h3FF3E, 18'h3FEF4, 18'h3FF3F, 18'h3FF61, 18'h3FF18,
    18'h3FF62, 18'h3FF63, 18'h3FF3C, 18'h3FF85, 18'h3FF86, 18'h3FF60,
    18'h3FF87, 18'h3FFA9, 18'h3FF84, 18'h3FFAA, 18'h3FFAB, 18'h3FFA8,
    18'h3FFD1, 18'h3FFD2, 18'h3FFD0, 18'h3FFD3, 18'h3FFF9, 18'h3FFF8,
    18'h3FFFA, 18'h3FFFB};

  // run in the high nibble, size in the low; zero is end of block
  localparam logic [7:0] AC_SYM_TAB [AC_COUNT] = '{
    8'h01, 8'h02, 8'h03, 8'h04, 8'h11, 8'h00, 8'h05, 8'h12, 8'h21, 8'h31, 8'h41,
    8'h06, 8'h13, 8'h51, 8'h61, 8'h07, 8'h22, 8'h71, 8'h14, 8'h32, 8'h81, 8'h91,
    8'hA1, 8'h08, 8'h23, 8'h42, 8'hB1, 8'hC1, 8'hD1, 8'hF0, 8'h0C, 8'h09, 8'h0A,
    8'h0B, 8'h15, 8'h62, 8'h24, 8'h33, 8'h52, 8'h72, 8'h82, 8'h16, 8'h17, 8'h18,
    8'h19, 8'h1A, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h3A, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
    8'h4A, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h63, 8'h64,
    8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78,
    8'h79, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h92, 8'h93, 8'h94,
    8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'hA2, 8'hA3, 8'hA4, 8'hA5, 8'hA6, 8'hA7,
    8'hA8, 8'hA9, 8'hB2, 8'hB3, 8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB8, 8'hB9, 8'hC2,
    8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7, 8'hC8, 8'hC9, 8'hD2, 8'hD3, 8'hD4, 8'hD5,
    8'hD6, 8'hD7, 8'hD8, 8'hD9, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6, 8'hE7,
    8'hE8, 8'hE9, 8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6, 8'hF7, 8'hF8, 8'hF9,
    8'h1B, 8'h1C, 8'h2B, 8'h2C, 8'h3B, 8'h3C, 8'h4B, 8'h4C, 8'h5B, 8'h5C, 8'h6A,
    8'h6B, 8'h6C, 8'h7A, 8'h7B, 8'h7C, 8'h8A, 8'h8B, 8'h8C, 8'h9A, 8'h9B, 8'h9C,
    8'hAA, 8'hAB, 8'hAC, 8'hBA, 8'hBB, 8'hBC, 8'hCA, 8'hCB, 8'hCC, 8'hDA, 8'hDB,
    8'hDC, 8'hEA, 8'hEB, 8'hEC, 8'hFA, 8'hFB, 8'hFC};

  function automatic logic [4:0] ac_len_of(input int k);
    if (k < 40) return AC_SHORT_LEN[k];
    if (k == 40) return 5'd15;
    if (k < 154) return 5'd16;
    return 5'd18;
  endfunction

  // {hit, index}
  function automatic logic [4:0] dc_match(input logic [17:0] sh, input logic [4:0] ln);
    logic [4:0] r;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      if (!r[4] && DC_LEN_TAB[k] == ln && DC_CODE_TAB[k] == sh) r = {1'b1, 4'(k)};
    end
    return r;
  endfunction

  // {hit, symbol}
  function automatic logic [8:0] ac_match(input logic [17:0] sh, input logic [4:0] ln);
    logic [8:0] r;
    r = '0;
    for (int k = 0; k < AC_COUNT; k++) begin
      if (!r[8] && ac_len_of(k) == ln && AC_CODE_TAB[k] == sh) r = {1'b1, AC_SYM_TAB[k]};
    end
    return r;
  endfunction

  // magnitude-coded field of n bits to a signed value
  function automatic logic signed [16:0] mag_extend(input logic [15:0] fv,
                                                     input logic [3:0] n);
    logic [16:0] mask;
    logic [16:0] low;
    mask = (17'd1 << n) - 17'd1;
    low  = {1'b0, fv & mask[15:0]};
    if (n == 4'd0) return '0;
    if (fv[n - 4'd1]) return $signed(low);
    return $signed(low - mask);
  endfunction

endpackage
`default_nettype wire

[rtl/rbcd_if.sv]
// Request channel interfaces for the coefficient decoder.
// No dependencies; the result kind is a plain two-bit field.
`default_nettype none
interface rbcd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        quant_table;
  logic [5:0]  quant_index;
  logic [30:0] quant_value;
  logic        block_kind;
  logic [1:0]  predictor_select;
  logic        stream_bit;
  modport source (output valid, command, quant_table, quant_index, quant_value,
                  block_kind, predictor_select, stream_bit, input ready);
  modport sink (input valid, command, quant_table, quant_index, quant_value,
                block_kind, predictor_select, stream_bit, output ready);
endinterface

interface rbcd_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        result_kind;
  logic [5:0]        coef_position;
  logic signed [15:0] coef_value;
  modport source (output valid, result_kind, coef_position, coef_value, input ready);
  modport sink (input valid, result_kind, coef_position, coef_value, output ready);
endinterface
`default_nettype wire

[rtl/rbcd_ram.sv]
// Generic single-port RAM with registered read and read enable.
// No dependencies.
`default_nettype none
module rbcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[rtl/rbcd_parser.sv]
// Bit-serial prefix-code parser: commands, DC predictors, run/size decode.
// Depends on rbcd_pkg; emits one issue_t per request that yields a result.
`default_nettype none
module rbcd_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic [1:0]      command,
  input  wire logic            block_kind,
  input  wire logic [1:0]      predictor_select,
  input  wire logic            stream_bit,
  output rbcd_pkg::issue_t     issue
);
  import rbcd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_DC_CODE, PH_DC_BITS, PH_AC_CODE, PH_AC_BITS
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [17:0]   shift_r, shift_nxt;
  logic [4:0]    len_r, len_nxt;
  logic [3:0]    left_r, left_nxt;
  logic [15:0]   fv_r, fv_nxt;
  logic [6:0]    ci_r, ci_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic          half_r, half_nxt;
  logic [1:0]    psel_r, psel_nxt;
  logic [2:0][31:0] pred_r, pred_nxt;

  logic [17:0]   sh;
  logic [4:0]    ln;
  logic [4:0]    dcm;
  logic [8:0]    acm;
  logic [6:0]    ci_adv;
  logic [15:0]   fv_sh;
  logic [3:0]    left_dec;
  logic signed [16:0] ext;
  logic [31:0]   nv;
  logic [5:0]    pos;

  always_comb begin
    phase_nxt = phase_r;  shift_nxt = shift_r;  len_nxt = len_r;
    left_nxt  = left_r;   fv_nxt    = fv_r;     ci_nxt  = ci_r;
    pend_nxt  = pend_r;   half_nxt  = half_r;   psel_nxt = psel_r;
    pred_nxt  = pred_r;
    issue     = '0;
    issue.half = half_r;

    sh       = {shift_r[16:0], stream_bit};
    ln       = len_r + 5'd1;
    dcm      = dc_match(sh, ln);
    acm      = ac_match(sh, ln);
    ci_adv   = ci_r + 7'd1 + {3'b000, acm[7:4]};
    fv_sh    = {fv_r[14:0], stream_bit};
    left_dec = left_r - 4'd1;
    ext      = mag_extend(fv_sh, pend_r[3:0]);
    nv       = pred_r[psel_r] + 32'(ext);
    pos      = half_r ? HALF_ORDER[ci_r[4:0]] : ZZ_ORDER[ci_r[5:0]];

    if (accept) begin
      case (command)
        CMD_QWRITE: begin
        end
        CMD_TILE: begin
          pred_nxt  = '0;
          phase_nxt = PH_IDLE;
        end
        CMD_BLOCK: begin
          half_nxt  = block_kind;
          psel_nxt  = (predictor_select == 2'd3) ? 2'd2 : predictor_select;
          phase_nxt = PH_DC_CODE;
          shift_nxt = '0; len_nxt = '0; ci_nxt = '0;
          left_nxt  = '0; fv_nxt  = '0; pend_nxt = '0;
        end
        default: begin
          case (phase_r)
            PH_DC_CODE: begin
              shift_nxt = sh;
              len_nxt   = ln;
              if (dcm[4]) begin
                shift_nxt = '0;
                len_nxt   = '0;
                if (dcm[3:0] == 4'd0) begin
                  // zero difference: finish DC at once
                  pred_nxt[psel_r] = pred_r[psel_r];
                  issue.vld   = 1'b1;
                  issue.kind  = RK_COEF;
                  issue.is_dc = 1'b1;
                  issue.value = $signed(pred_r[psel_r]);
                  phase_nxt   = PH_AC_CODE;
                end else begin
                  phase_nxt = PH_DC_BITS;
                  left_nxt  = dcm[3:0];
                  fv_nxt    = '0;
                  pend_nxt  = {4'd0, dcm[3:0]};
                end
              end else if (ln >= 5'(MAX_DC_CODE_BITS)) begin
                issue.vld  = 1'b1;
                issue.kind = RK_ERR;
                phase_nxt  = PH_IDLE;
              end
            end
            PH_AC_CODE: begin
              shift_nxt = sh;
              len_nxt   = ln;
              if (acm[8]) begin
                shift_nxt = '0;
                len_nxt   = '0;
                if (acm[7:0] == 8'd0) begin
                  issue.vld  = 1'b1;
                  issue.kind = RK_EOB;
                  phase_nxt  = PH_IDLE;
                end else begin
                  ci_nxt = ci_adv;
                  if (half_r ? (ci_adv[6:5] != 2'd0) : ci_adv[6]) begin
                    issue.vld  = 1'b1;
                    issue.kind = RK_ERR;
                    phase_nxt  = PH_IDLE;
                  end else if (acm[3:0] != 4'd0) begin
                    phase_nxt = PH_AC_BITS;
                    left_nxt  = acm[3:0];
                    fv_nxt    = '0;
                    pend_nxt  = acm[7:0];
                  end
                end
              end else if (ln >= 5'(MAX_AC_CODE_BITS)) begin
                issue.vld  = 1'b1;
                issue.kind = RK_ERR;
                phase_nxt  = PH_IDLE;
              end
            end
            PH_DC_BITS, PH_AC_BITS: begin
              fv_nxt   = fv_sh;
              left_nxt = left_dec;
              if (left_dec == 4'd0) begin
                issue.vld  = 1'b1;
                issue.kind = RK_COEF;
                phase_nxt  = PH_AC_CODE;
                if (phase_r == PH_DC_BITS) begin
                  pred_nxt[psel_r] = nv;
                  issue.is_dc = 1'b1;
                  issue.value = $signed(nv);
                end else begin
                  issue.pos   = pos;
                  issue.value = 32'(ext);
                end
              end
            end
            default: begin
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; shift_r <= '0; len_r <= '0; left_r <= '0;
      fv_r <= '0; ci_r <= '0; pend_r <= '0; half_r <= 1'b0; psel_r <= '0;
      pred_r <= '0;
    end else begin
      phase_r <= phase_nxt; shift_r <= shift_nxt; len_r <= len_nxt;
      left_r <= left_nxt; fv_r <= fv_nxt; ci_r <= ci_nxt; pend_r <= pend_nxt;
      half_r <= half_nxt; psel_r <= psel_nxt; pred_r <= pred_nxt;
    end
  end
endmodule
`default_nettype wire

[rtl/rbcd_dequant.sv]
// Dequantiser pipeline: RAM read stage, multiply stage, round/clamp output (clamp for DC only).
// Depends on rbcd_pkg and the assertion macros header.
`default_nettype none
`include "raw_block_coefficient_decoder_macros.svh"
module rbcd_dequant (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rbcd_pkg::issue_t              issue,
  input  wire logic [rbcd_pkg::QDATA_W-1:0]  qdata,
  input  wire logic                          out_ready,
  output logic                               adv,
  output logic                               out_valid,
  output logic [1:0]                         out_kind,
  output logic [5:0]                         out_pos,
  output logic signed [15:0]                 out_value
);
  import rbcd_pkg::*;

  issue_t             s1_r;
  logic               s2_vld_r;
  rkind_t             s2_kind_r;
  logic [5:0]         s2_pos_r;
  logic               s2_dc_r;
  logic               s2_half_r;
  logic signed [63:0] s2_prod_r;
  logic               s3_vld_r;
  rkind_t             out_kind_r;
  logic [5:0]         out_pos_r;
  logic signed [15:0] out_value_r;

  logic signed [63:0] prod_nxt;
  logic signed [63:0] rnd;
  logic signed [47:0] t;
  logic signed [47:0] td;
  logic signed [15:0] val_nxt;

  assign adv = !s3_vld_r || out_ready;

  always_comb begin
    prod_nxt = s1_r.value * $signed({1'b0, qdata});
    rnd      = s2_prod_r + 64'sd32768;
    t        = rnd[63:16];
    td       = t;
    if (s2_dc_r) begin
      td = t + (s2_half_r ? 48'sd8192 : 48'sd16384);
      if (td > 48'sd32767) td = 48'sd32767;
    end
    val_nxt = (s2_kind_r == RK_COEF) ? td[15:0] : 16'sd0;
  end

  // valid bits reset; payload only moves when the pipeline advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s1_r.vld    <= issue.vld;
      s2_vld_r    <= s1_r.vld;
      s3_vld_r    <= s2_vld_r;
      s1_r.kind   <= issue.kind;
      s1_r.pos    <= issue.pos;
      s1_r.is_dc  <= issue.is_dc;
      s1_r.half   <= issue.half;
      s1_r.value  <= issue.value;
      s2_kind_r   <= s1_r.kind;
      s2_pos_r    <= s1_r.pos;
      s2_dc_r     <= s1_r.is_dc;
      s2_half_r   <= s1_r.half;
      s2_prod_r   <= prod_nxt;
      out_kind_r  <= s2_kind_r;
      out_pos_r   <= (s2_kind_r == RK_COEF) ? s2_pos_r : 6'd0;
      out_value_r <= val_nxt;
    end
  end

  assign out_valid = s3_vld_r;
  assign out_kind  = out_kind_r;
  assign out_pos   = out_pos_r;
  assign out_value = out_value_r;

  `RBCD_ASSERT_IMPL(a_kind_legal, s3_vld_r, out_kind_r == RK_COEF || out_kind_r == RK_EOB || out_kind_r == RK_ERR)
  `RBCD_ASSERT_IMPL(a_side_zero, s3_vld_r && out_kind_r != RK_COEF, out_value_r == 16'sd0 && out_pos_r == 6'd0)
  `RBCD_ASSERT_NEXT(a_stall_hold, s1_r.vld && !adv, s1_r.vld)
endmodule
`default_nettype wire

[rtl/raw_block_coefficient_decoder.sv]
// Raw block coefficient decoder top level: parser, quant table RAM and
// dequantiser pipeline. Depends on rbcd_pkg, rbcd_if and the submodules.
//
// Takes one request per cycle unless stalled (quant write, tile start,
// block start or one compressed bit) and gives at most one result per
// request: a dequantised coefficient at its natural position, end of block,
// or an invalid data error. Rate is one request per clock unless stalled;
// the prefix-code parser consumes one bit per cycle and the quant table RAM
// gives one read per cycle. A completed coefficient passes the RAM read,
// multiply and round/clamp stages. The whole pipeline stalls only while
// the output register holds a result that is not taken. The quant table
// RAM has no reset; entries must be written before use.
`default_nettype none
module raw_block_coefficient_decoder (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rbcd_in_if.sink     in_ch,
  rbcd_out_if.source  out_ch
);
  import rbcd_pkg::*;

  logic                 adv;
  logic                 accept;
  logic                 qwe;
  logic [QADDR_W-1:0]   qaddr;
  logic [QDATA_W-1:0]   qdata;
  issue_t               issue;
  logic [1:0]           kind;

  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;
  assign qwe         = accept && (in_ch.command == CMD_QWRITE);
  // coefficient read address; DC reads position zero of its table
  assign qaddr = qwe ? {in_ch.quant_table, in_ch.quant_index} : {issue.half, issue.pos};

  rbcd_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .command          (in_ch.command),
    .block_kind       (in_ch.block_kind),
    .predictor_select (in_ch.predictor_select),
    .stream_bit       (in_ch.stream_bit),
    .issue            (issue)
  );

  rbcd_ram #(.WIDTH(QDATA_W), .DEPTH(1 << QADDR_W)) u_qram (
    .clk   (clk),
    .we    (qwe),
    .re    (issue.vld),
    .addr  (qaddr),
    .wdata (in_ch.quant_value),
    .rdata (qdata)
  );

  rbcd_dequant u_dequant (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .qdata     (qdata),
    .out_ready (out_ch.ready),
    .adv       (adv),
    .out_valid (out_ch.valid),
    .out_kind  (kind),
    .out_pos   (out_ch.coef_position),
    .out_value (out_ch.coef_value)
  );

  assign out_ch.result_kind = kind;
endmodule
`default_nettype wire
